>>> src/tree_object_entry_parser_top_macros.svh
// Assertion macros shared by the tree object entry parser checker.
// Depends on nothing; included by the checker file.
`ifndef TREE_OBJECT_ENTRY_PARSER_TOP_MACROS_SVH
`define TREE_OBJECT_ENTRY_PARSER_TOP_MACROS_SVH

// Concurrent assertion that is disabled while reset is asserted.
`define TOEP_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Concurrent assertion that is also checked during reset.
`define TOEP_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> src/toep_pkg.sv
// Package for the tree object entry parser: default sizes, result codes and widths.
// Depends on nothing; used by the top level and its checker.
package toep_pkg;

    localparam int NAME_CAPACITY_DEF      = 256;
    localparam int MAX_ENTRIES_DEF        = 128;
    localparam int HASH_BYTES_DEF         = 32;
    localparam int MODE_TEXT_CAPACITY_DEF = 16;

    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = 72;
    localparam int M_USER_W = 2;

    localparam logic [1:0] KIND_MODE    = 2'd0;
    localparam logic [1:0] KIND_NAME    = 2'd1;
    localparam logic [1:0] KIND_HASH    = 2'd2;
    localparam logic [1:0] KIND_IGNORED = 2'd3;

    localparam logic [2:0] CAUSE_NONE       = 3'd0;
    localparam logic [2:0] CAUSE_MODE_LONG  = 3'd1;
    localparam logic [2:0] CAUSE_NAME_LONG  = 3'd2;
    localparam logic [2:0] CAUSE_END_ENTRY  = 3'd3;
    localparam logic [2:0] CAUSE_END_HASH   = 3'd4;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

endpackage

>>> src/tree_object_entry_parser_top.sv
// A result is registered and appears on the master side in the cycle after its byte request is accepted.
// Throughput: one byte per cycle while m_tready is high; the result register alone sets it.
// Reset: synchronous active-low aresetn clears all parser state and the result valid,
// and the parser also returns to its reset state after each byte marked by s_tlast.
// Top level of the tree object entry parser; holds the byte parser and result register.
// Depends on toep_pkg.
module tree_object_entry_parser_top
    import toep_pkg::*;
#(
    parameter int NAME_CAPACITY      = NAME_CAPACITY_DEF,
    parameter int MAX_ENTRIES        = MAX_ENTRIES_DEF,
    parameter int HASH_BYTES         = HASH_BYTES_DEF,
    parameter int MODE_TEXT_CAPACITY = MODE_TEXT_CAPACITY_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // [7:0] data_byte
    input  logic                s_tlast,   // last_byte
    output logic                m_tvalid,
    input  logic                m_tready,
    // [6:0] entry_index, [14:7] byte_position, [22:15] byte_value,
    // [23] entry_complete, [55:24] entry_mode, [56] parse_failed,
    // [59:57] failure_cause, [67:60] entries_parsed, [71:68] zero
    output logic [M_DATA_W-1:0] m_tdata,
    output logic [M_USER_W-1:0] m_tuser,   // [1:0] byte_kind
    output logic                m_tlast    // object_finished
);

    localparam int NL = $clog2(NAME_CAPACITY);
    localparam int ML = $clog2(MODE_TEXT_CAPACITY);
    localparam int HW = $clog2(HASH_BYTES + 1);
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    localparam logic [NL-1:0] NAME_LAST = NL'(NAME_CAPACITY - 1);
    localparam logic [ML-1:0] MODE_LAST = ML'(MODE_TEXT_CAPACITY - 1);
    localparam logic [HW-1:0] HASH_LAST = HW'(HASH_BYTES - 1);
    localparam logic [CW-1:0] ENTRY_MAX = CW'(MAX_ENTRIES);

    typedef enum logic [1:0] {
        PHASE_MODE,
        PHASE_NAME,
        PHASE_HASH
    } phase_t;

    typedef enum logic [1:0] {
        SUB_SPACE,
        SUB_SIGN,
        SUB_DIGITS,
        SUB_DONE
    } sub_phase_t;

    phase_t          phase_reg, phase_upd, phase_next;
    sub_phase_t      sub_reg, sub_upd, sub_next;
    logic [31:0]     mode_val_reg, mode_val_upd, mode_val_next;
    logic            mode_neg_reg, mode_neg_upd, mode_neg_next;
    logic [ML-1:0]   mode_len_reg, mode_len_upd, mode_len_next;
    logic [NL-1:0]   name_len_reg, name_len_upd, name_len_next;
    logic [HW-1:0]   hash_pos_reg, hash_pos_upd, hash_pos_next;
    logic [CW-1:0]   entry_cnt_reg, entry_cnt_upd, entry_cnt_next;
    logic            err_flag_reg, err_flag_upd, err_flag_next;
    logic [2:0]      err_code_reg, err_code_upd, err_code_next;

    logic            m_valid_reg;
    logic [M_DATA_W-1:0] m_data_reg;
    logic [M_USER_W-1:0] m_user_reg;
    logic            m_last_reg;

    logic            accept;
    logic [7:0]      b;
    logic            is_digit, is_ws, active;
    logic [1:0]      kind;
    logic [31:0]     pos_ext, idx_ext, cnt_ext;
    logic [7:0]      val;
    logic            done;
    logic [31:0]     mode_out;
    logic [M_DATA_W-1:0] data_next;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = !m_valid_reg || m_tready;
    assign b        = s_tdata;
    assign is_digit = (b >= 8'h30) && (b <= 8'h37);
    assign is_ws    = (b >= 8'h09) && (b <= 8'h0D);
    assign active   = !err_flag_reg && (entry_cnt_reg < ENTRY_MAX);

    always_comb begin
        phase_upd     = phase_reg;
        sub_upd       = sub_reg;
        mode_val_upd  = mode_val_reg;
        mode_neg_upd  = mode_neg_reg;
        mode_len_upd  = mode_len_reg;
        name_len_upd  = name_len_reg;
        hash_pos_upd  = hash_pos_reg;
        entry_cnt_upd = entry_cnt_reg;
        err_flag_upd  = err_flag_reg;
        err_code_upd  = err_code_reg;
        kind          = KIND_IGNORED;
        pos_ext       = 32'd0;
        val           = 8'd0;
        done          = 1'b0;
        mode_out      = 32'd0;
        if (active) begin
            unique case (phase_reg)
                PHASE_MODE: begin
                    if (b == CHAR_SPACE) begin
                        kind      = KIND_MODE;
                        phase_upd = PHASE_NAME;
                    end else if (mode_len_reg == MODE_LAST) begin
                        err_flag_upd = 1'b1;
                        err_code_upd = CAUSE_MODE_LONG;
                    end else begin
                        kind         = KIND_MODE;
                        mode_len_upd = mode_len_reg + ML'(1);
                        if (sub_reg == SUB_SPACE && is_ws) begin
                            sub_upd = sub_reg;
                        end else if (sub_reg == SUB_SPACE &&
                                     (b == CHAR_PLUS || b == CHAR_MINUS)) begin
                            mode_neg_upd = (b == CHAR_MINUS);
                            sub_upd      = SUB_SIGN;
                        end else if (sub_reg != SUB_DONE && is_digit) begin
                            mode_val_upd = {mode_val_reg[28:0], b[2:0]};
                            sub_upd      = SUB_DIGITS;
                        end else begin
                            sub_upd = SUB_DONE;
                        end
                    end
                end
                PHASE_NAME: begin
                    if (b == CHAR_NUL) begin
                        kind      = KIND_MODE;
                        phase_upd = PHASE_HASH;
                    end else if (name_len_reg == NAME_LAST) begin
                        err_flag_upd = 1'b1;
                        err_code_upd = CAUSE_NAME_LONG;
                    end else begin
                        kind         = KIND_NAME;
                        pos_ext      = 32'(name_len_reg);
                        val          = b;
                        name_len_upd = name_len_reg + NL'(1);
                    end
                end
                default: begin
                    kind         = KIND_HASH;
                    pos_ext      = 32'(hash_pos_reg);
                    val          = b;
                    hash_pos_upd = hash_pos_reg + HW'(1);
                    if (hash_pos_reg == HASH_LAST) begin
                        done          = 1'b1;
                        mode_out      = mode_neg_reg ? (32'd0 - mode_val_reg) : mode_val_reg;
                        entry_cnt_upd = entry_cnt_reg + CW'(1);
                        phase_upd     = PHASE_MODE;
                        mode_val_upd  = 32'd0;
                        sub_upd       = SUB_SPACE;
                        mode_neg_upd  = 1'b0;
                        mode_len_upd  = '0;
                        name_len_upd  = '0;
                        hash_pos_upd  = '0;
                    end
                end
            endcase
            if (s_tlast && !err_flag_upd) begin
                if (phase_upd == PHASE_HASH) begin
                    err_flag_upd = 1'b1;
                    err_code_upd = CAUSE_END_HASH;
                end else if (phase_upd == PHASE_NAME || mode_len_upd != '0) begin
                    err_flag_upd = 1'b1;
                    err_code_upd = CAUSE_END_ENTRY;
                end
            end
        end
    end

    always_comb begin
        phase_next     = phase_upd;
        sub_next       = sub_upd;
        mode_val_next  = mode_val_upd;
        mode_neg_next  = mode_neg_upd;
        mode_len_next  = mode_len_upd;
        name_len_next  = name_len_upd;
        hash_pos_next  = hash_pos_upd;
        entry_cnt_next = entry_cnt_upd;
        err_flag_next  = err_flag_upd;
        err_code_next  = err_code_upd;
        if (s_tlast) begin
            phase_next     = PHASE_MODE;
            sub_next       = SUB_SPACE;
            mode_val_next  = 32'd0;
            mode_neg_next  = 1'b0;
            mode_len_next  = '0;
            name_len_next  = '0;
            hash_pos_next  = '0;
            entry_cnt_next = '0;
            err_flag_next  = 1'b0;
            err_code_next  = CAUSE_NONE;
        end
    end

    assign idx_ext = 32'(entry_cnt_reg);
    assign cnt_ext = 32'(entry_cnt_upd);

    assign data_next = {4'd0, cnt_ext[7:0], err_code_upd, err_flag_upd, mode_out, done,
                        val, pos_ext[7:0], idx_ext[6:0]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PHASE_MODE;
            sub_reg       <= SUB_SPACE;
            mode_val_reg  <= 32'd0;
            mode_neg_reg  <= 1'b0;
            mode_len_reg  <= '0;
            name_len_reg  <= '0;
            hash_pos_reg  <= '0;
            entry_cnt_reg <= '0;
            err_flag_reg  <= 1'b0;
            err_code_reg  <= CAUSE_NONE;
            m_valid_reg   <= 1'b0;
        end else begin
            if (accept) begin
                phase_reg     <= phase_next;
                sub_reg       <= sub_next;
                mode_val_reg  <= mode_val_next;
                mode_neg_reg  <= mode_neg_next;
                mode_len_reg  <= mode_len_next;
                name_len_reg  <= name_len_next;
                hash_pos_reg  <= hash_pos_next;
                entry_cnt_reg <= entry_cnt_next;
                err_flag_reg  <= err_flag_next;
                err_code_reg  <= err_code_next;
                m_valid_reg   <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= data_next;
            m_user_reg <= kind;
            m_last_reg <= s_tlast;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

endmodule

>>> src/toep_checker.sv
// Port-level checker for the tree object entry parser, bound to its top level.
// Depends on toep_pkg and tree_object_entry_parser_top_macros.svh.
`include "tree_object_entry_parser_top_macros.svh"

module toep_checker
    import toep_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic [S_DATA_W-1:0] s_tdata,
    input logic                s_tlast,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata,
    input logic [M_USER_W-1:0] m_tuser,
    input logic                m_tlast
);

    `TOEP_ASSERT_NR(a_reset_clears_valid, aclk, !aresetn |=> !m_tvalid, "result valid after reset")
    `TOEP_ASSERT(a_stall_holds, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled result request changed")
    `TOEP_ASSERT(a_complete_is_hash, aclk, aresetn, m_tvalid && m_tdata[23] |-> m_tuser == KIND_HASH, "entry completed on a non-hash byte")
    `TOEP_ASSERT(a_quiet_fields, aclk, aresetn, m_tvalid && m_tuser != KIND_NAME && m_tuser != KIND_HASH |-> m_tdata[22:7] == 16'd0, "position or value set on a mode or ignored byte")
    `TOEP_ASSERT(a_cause_matches_flag, aclk, aresetn, m_tvalid |-> m_tdata[56] == (m_tdata[59:57] != CAUSE_NONE), "failure flag and cause disagree")

endmodule

bind tree_object_entry_parser_top toep_checker u_toep_checker (.*);

>>> tb/tb_tree_object_entry_parser_top.sv
// Self-checking testbench for the tree object entry parser top level.
// It drives byte requests with random gaps, predicts each result and compares it
// field by field. Depends on toep_pkg and tree_object_entry_parser_top.
module tb_tree_object_entry_parser_top
    import toep_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [1:0] {PH_MODE, PH_NAME, PH_HASH} field_phase_t;
    typedef enum logic [1:0] {MS_SKIP_WS, MS_SIGNED, MS_DIGITS, MS_STOPPED} mode_scan_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [6:0]  idx;
        logic [7:0]  pos;
        logic [7:0]  val;
        logic        done;
        logic [31:0] mode;
        logic        fin;
        logic        failed;
        logic [2:0]  cause;
        logic [7:0]  count;
    } byte_report_t;

    typedef struct {
        logic [7:0]   data;
        logic         fin;
        int           count;
        bit           typed;
        byte_report_t result;
    } stim_row_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic                s_tlast = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic [M_USER_W-1:0] m_tuser;
    logic                m_tlast;

    field_phase_t phase;
    mode_scan_t   scan;
    logic [31:0]  mode_acc;
    logic         mode_neg;
    int           mode_chars;
    int           name_chars;
    int           hash_idx;
    int           entries_done;
    logic         obj_failed;
    logic [2:0]   obj_cause;

    byte_report_t byte_reports_due[$];
    byte_report_t due;
    logic [7:0]   object_bytes[$];
    stim_row_t    directed_rows[];
    int           mismatches = 0;
    int           bytes_sent = 0;
    int           send_run = 0;
    int           recv_run = 0;

    always #10 aclk = ~aclk;

    tree_object_entry_parser_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    function void clear_entry();
        phase      = PH_MODE;
        scan       = MS_SKIP_WS;
        mode_acc   = '0;
        mode_neg   = 1'b0;
        mode_chars = 0;
        name_chars = 0;
        hash_idx   = 0;
    endfunction

    function void clear_object();
        clear_entry();
        entries_done = 0;
        obj_failed   = 1'b0;
        obj_cause    = CAUSE_NONE;
    endfunction

    function automatic byte_report_t predict_byte_report(input logic [7:0] b, input logic fin);
        byte_report_t r;
        logic         is_digit;
        logic         is_ws;
        r        = '0;
        r.kind   = KIND_IGNORED;
        r.idx    = entries_done[6:0];
        is_digit = (b >= 8'h30) && (b <= 8'h37);
        is_ws    = (b >= 8'h09) && (b <= 8'h0D);
        if (!obj_failed && entries_done < MAX_ENTRIES_DEF) begin
            if (phase == PH_MODE) begin
                if (b == CHAR_SPACE) begin
                    r.kind = KIND_MODE;
                    phase  = PH_NAME;
                end else if (mode_chars + 1 >= MODE_TEXT_CAPACITY_DEF) begin
                    obj_failed = 1'b1;
                    obj_cause  = CAUSE_MODE_LONG;
                end else begin
                    r.kind = KIND_MODE;
                    mode_chars++;
                    if (scan == MS_SKIP_WS && is_ws) begin
                        scan = MS_SKIP_WS;
                    end else if (scan == MS_SKIP_WS && (b == CHAR_PLUS || b == CHAR_MINUS)) begin
                        mode_neg = (b == CHAR_MINUS);
                        scan     = MS_SIGNED;
                    end else if (scan != MS_STOPPED && is_digit) begin
                        mode_acc = {mode_acc[28:0], b[2:0]};
                        scan     = MS_DIGITS;
                    end else begin
                        scan = MS_STOPPED;
                    end
                end
            end else if (phase == PH_NAME) begin
                if (b == CHAR_NUL) begin
                    r.kind = KIND_MODE;
                    phase  = PH_HASH;
                end else if (name_chars + 1 >= NAME_CAPACITY_DEF) begin
                    obj_failed = 1'b1;
                    obj_cause  = CAUSE_NAME_LONG;
                end else begin
                    r.kind = KIND_NAME;
                    r.pos  = name_chars[7:0];
                    r.val  = b;
                    name_chars++;
                end
            end else begin
                r.kind = KIND_HASH;
                r.pos  = hash_idx[7:0];
                r.val  = b;
                hash_idx++;
                if (hash_idx >= HASH_BYTES_DEF) begin
                    r.done = 1'b1;
                    r.mode = mode_neg ? (32'd0 - mode_acc) : mode_acc;
                    entries_done++;
                    clear_entry();
                end
            end
            if (fin && !obj_failed) begin
                if (phase == PH_HASH) begin
                    obj_failed = 1'b1;
                    obj_cause  = CAUSE_END_HASH;
                end else if (phase == PH_NAME || mode_chars > 0) begin
                    obj_failed = 1'b1;
                    obj_cause  = CAUSE_END_ENTRY;
                end
            end
        end
        r.fin    = fin;
        r.failed = obj_failed;
        r.cause  = obj_cause;
        r.count  = entries_done[7:0];
        if (fin) begin
            clear_object();
        end
        return r;
    endfunction

    function automatic int draw_wait(inout int run);
        if (run > 0) begin
            run--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            run = $urandom_range(10, 30);
            return 0;
        end
        return $urandom_range(0, 6);
    endfunction

    function automatic stim_row_t pred_row(input logic [7:0] d, input logic f, input int n);
        stim_row_t s;
        s.data   = d;
        s.fin    = f;
        s.count  = n;
        s.typed  = 1'b0;
        s.result = '0;
        return s;
    endfunction

    function automatic stim_row_t typed_row(input logic [7:0] d, input logic f,
                                            input logic [1:0] k, input logic [7:0] p,
                                            input logic [7:0] v, input logic fl,
                                            input logic [2:0] c);
        stim_row_t s;
        s          = pred_row(d, f, 1);
        s.typed    = 1'b1;
        s.result.kind   = k;
        s.result.pos    = p;
        s.result.val    = v;
        s.result.fin    = f;
        s.result.failed = fl;
        s.result.cause  = c;
        return s;
    endfunction

    function void add_mode_text(input bit tame);
        logic [7:0] c;
        if (!tame && $urandom_range(0, 19) == 0) begin
            repeat ($urandom_range(15, 18)) begin
                c = 8'($urandom_range(0, 255));
                if (c == CHAR_SPACE) begin
                    c = 8'h37;
                end
                object_bytes.push_back(c);
            end
            return;
        end
        repeat ($urandom_range(0, 2)) begin
            c = 8'($urandom_range(9, 13));
            object_bytes.push_back(c);
        end
        case ($urandom_range(0, 3))
            0: object_bytes.push_back(CHAR_PLUS);
            1: object_bytes.push_back(CHAR_MINUS);
            default: ;
        endcase
        repeat ($urandom_range(0, 11)) begin
            c = 8'h30 + 8'($urandom_range(0, 7));
            object_bytes.push_back(c);
        end
        if ($urandom_range(0, 4) == 0) begin
            c = 8'($urandom_range(0, 255));
            if (c == CHAR_SPACE) begin
                c = 8'h38;
            end
            object_bytes.push_back(c);
        end
    endfunction

    function void add_entry(input bit tame, input int forced_name);
        int         name_bytes;
        logic [7:0] c;
        add_mode_text(tame);
        object_bytes.push_back(CHAR_SPACE);
        if (forced_name >= 0) begin
            name_bytes = forced_name;
        end else if (!tame && $urandom_range(0, 29) == 0) begin
            name_bytes = $urandom_range(255, 256);
        end else begin
            name_bytes = $urandom_range(0, tame ? 2 : 12);
        end
        repeat (name_bytes) begin
            c = 8'($urandom_range(1, 255));
            object_bytes.push_back(c);
        end
        object_bytes.push_back(CHAR_NUL);
        repeat (HASH_BYTES_DEF) begin
            c = 8'($urandom_range(0, 255));
            object_bytes.push_back(c);
        end
    endfunction

    function void build_object(input int forced_name);
        int         variant;
        int         cut;
        logic [7:0] c;
        object_bytes.delete();
        variant = (forced_name >= 0) ? 0 : $urandom_range(0, 9);
        for (int e = 0; e < $urandom_range(1, 2); e++) begin
            add_entry(1'b0, (e == 0) ? forced_name : -1);
        end
        if (variant == 6 || variant == 7) begin
            cut = $urandom_range(1, object_bytes.size() - 1);
            while (object_bytes.size() > cut) begin
                void'(object_bytes.pop_back());
            end
        end else if (variant == 8) begin
            repeat ($urandom_range(1, 6)) begin
                c = 8'($urandom_range(0, 255));
                object_bytes.push_back(c);
            end
        end else if (variant == 9) begin
            object_bytes.delete();
            repeat ($urandom_range(1, 20)) begin
                c = 8'($urandom_range(0, 255));
                object_bytes.push_back(c);
            end
        end
    endfunction

    // One byte request per call; the expectation is queued before the request is offered.
    task automatic send_byte(input logic [7:0] b, input logic fin, input bit use_typed,
                             input byte_report_t typed_r);
        int           gap;
        byte_report_t predicted;
        gap       = draw_wait(send_run);
        predicted = predict_byte_report(b, fin);
        byte_reports_due.push_back(use_typed ? typed_r : predicted);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= fin;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        bytes_sent++;
    endtask

    task automatic send_object();
        for (int i = 0; i < object_bytes.size(); i++) begin
            send_byte(object_bytes[i], i == object_bytes.size() - 1, 1'b0, '0);
        end
    endtask

    function void compare_field(input string name, input logic [31:0] e, input logic [31:0] a);
        if (e !== a) begin
            mismatches++;
            $display("%0t: %s expected %0h actual %0h", $time, name, e, a);
        end
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (byte_reports_due.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result expected none actual tdata %h tuser %h",
                         $time, m_tdata, m_tuser);
            end else begin
                due = byte_reports_due.pop_front();
                compare_field("byte_kind", 32'(due.kind), 32'(m_tuser[1:0]));
                compare_field("entry_index", 32'(due.idx), 32'(m_tdata[6:0]));
                compare_field("byte_position", 32'(due.pos), 32'(m_tdata[14:7]));
                compare_field("byte_value", 32'(due.val), 32'(m_tdata[22:15]));
                compare_field("entry_complete", 32'(due.done), 32'(m_tdata[23]));
                compare_field("entry_mode", due.mode, m_tdata[55:24]);
                compare_field("object_finished", 32'(due.fin), 32'(m_tlast));
                compare_field("parse_failed", 32'(due.failed), 32'(m_tdata[56]));
                compare_field("failure_cause", 32'(due.cause), 32'(m_tdata[59:57]));
                compare_field("entries_parsed", 32'(due.count), 32'(m_tdata[67:60]));
            end
        end
    end

    // The long hold-off on one result lets the result register fill and stall the input side.
    initial begin
        int stall;
        int taken;
        taken = 0;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            stall = (taken == 150) ? 120 : draw_wait(recv_run);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            taken++;
        end
    end

    initial begin
        #10ms;
        $display("tb: failure");
        $finish;
    end

    initial begin
        int random_goal;
        clear_object();
        directed_rows = '{
            typed_row(CHAR_SPACE, 1'b0, KIND_MODE, 8'd0, 8'd0, 1'b0, CAUSE_NONE),
            typed_row(8'hFF, 1'b0, KIND_NAME, 8'd0, 8'hFF, 1'b0, CAUSE_NONE),
            typed_row(CHAR_NUL, 1'b1, KIND_MODE, 8'd0, 8'd0, 1'b1, CAUSE_END_HASH),
            typed_row(CHAR_PLUS, 1'b1, KIND_MODE, 8'd0, 8'd0, 1'b1, CAUSE_END_ENTRY),
            typed_row(CHAR_NUL, 1'b1, KIND_MODE, 8'd0, 8'd0, 1'b1, CAUSE_END_ENTRY),
            typed_row(CHAR_SPACE, 1'b1, KIND_MODE, 8'd0, 8'd0, 1'b1, CAUSE_END_ENTRY),
            pred_row(8'h37, 1'b0, 15),
            typed_row(8'h37, 1'b0, KIND_IGNORED, 8'd0, 8'd0, 1'b1, CAUSE_MODE_LONG),
            typed_row(CHAR_SPACE, 1'b1, KIND_IGNORED, 8'd0, 8'd0, 1'b1, CAUSE_MODE_LONG),
            pred_row(8'h09, 1'b0, 1),
            pred_row(8'h0D, 1'b0, 1),
            pred_row(CHAR_MINUS, 1'b0, 1),
            pred_row(8'h31, 1'b0, 1),
            pred_row(8'h38, 1'b0, 1),
            pred_row(8'h37, 1'b0, 1),
            pred_row(CHAR_SPACE, 1'b0, 1),
            pred_row(8'h01, 1'b0, 1),
            pred_row(8'h80, 1'b0, 1),
            pred_row(CHAR_NUL, 1'b0, 1),
            pred_row(8'h00, 1'b0, 31),
            pred_row(8'hFF, 1'b0, 1),
            pred_row(CHAR_PLUS, 1'b0, 1),
            pred_row(CHAR_SPACE, 1'b0, 1),
            pred_row(CHAR_NUL, 1'b0, 1),
            pred_row(8'hA5, 1'b0, 31),
            pred_row(8'h5A, 1'b1, 1),
            pred_row(8'h37, 1'b0, 11),
            pred_row(CHAR_SPACE, 1'b0, 1),
            pred_row(CHAR_NUL, 1'b0, 1),
            pred_row(8'h3C, 1'b0, 32),
            pred_row(8'h30, 1'b1, 1)
        };
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            repeat (directed_rows[i].count) begin
                send_byte(directed_rows[i].data, directed_rows[i].fin,
                          directed_rows[i].typed, directed_rows[i].result);
            end
        end

        // One object whose first name sits just under or at the name capacity.
        random_goal = 450;
        build_object(int'($urandom_range(NAME_CAPACITY_DEF - 1, NAME_CAPACITY_DEF)));
        send_object();
        while (bytes_sent < random_goal) begin
            build_object(-1);
            send_object();
        end

        s_tvalid <= 1'b0;
        while (byte_reports_due.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

>>> tree_object_entry_parser_top.f
+incdir+src
src/toep_pkg.sv
src/tree_object_entry_parser_top.sv
src/toep_checker.sv
tb/tb_tree_object_entry_parser_top.sv
